// File: hdl/bbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants for the bracket balance checker
// Character codes, bracket kind codes and the classified operation that
// travels from the front end through the queue to the stack engine.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int StackDepth = 128;
  localparam int QueueDepth = 2;

  localparam logic [7:0] LimitReset = 8'd100;

  localparam logic [7:0] ChOpenRound   = 8'h28;  // (
  localparam logic [7:0] ChCloseRound  = 8'h29;  // )
  localparam logic [7:0] ChOpenSquare  = 8'h5B;  // [
  localparam logic [7:0] ChCloseSquare = 8'h5D;  // ]
  localparam logic [7:0] ChOpenCurly   = 8'h7B;  // {
  localparam logic [7:0] ChCloseCurly  = 8'h7D;  // }

  typedef enum logic [1:0] {
    KindRound  = 2'd0,
    KindCurly  = 2'd1,
    KindSquare = 2'd2
  } kind_e;

  typedef struct packed {
    logic  is_open;
    logic  is_close;
    kind_e kind;
    logic  last;
  } op_t;

  localparam int OpW = $bits(op_t);

endpackage

// File: hdl/bbc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module bbc_ram #(
  parameter int Width = 2,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/bbc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_front: character classifier
// Decode each incoming character into an open, close or ignore operation
// with its bracket kind, ready for the queue.
// ----------------------------------------------------------------------------
module bbc_front (
  input  logic         ch_valid_i,
  input  logic [7:0]   ch_i,
  input  logic         last_i,
  output logic         ch_ready_o,
  output logic         op_valid_o,
  output bbc_pkg::op_t op_o,
  input  logic         op_ready_i
);

  always_comb begin
    op_o          = '0;
    op_o.last     = last_i;
    op_o.kind     = bbc_pkg::KindRound;
    case (ch_i)
      bbc_pkg::ChOpenRound: begin
        op_o.is_open = 1'b1;
        op_o.kind    = bbc_pkg::KindRound;
      end
      bbc_pkg::ChOpenCurly: begin
        op_o.is_open = 1'b1;
        op_o.kind    = bbc_pkg::KindCurly;
      end
      bbc_pkg::ChOpenSquare: begin
        op_o.is_open = 1'b1;
        op_o.kind    = bbc_pkg::KindSquare;
      end
      bbc_pkg::ChCloseRound: begin
        op_o.is_close = 1'b1;
        op_o.kind     = bbc_pkg::KindRound;
      end
      bbc_pkg::ChCloseCurly: begin
        op_o.is_close = 1'b1;
        op_o.kind     = bbc_pkg::KindCurly;
      end
      bbc_pkg::ChCloseSquare: begin
        op_o.is_close = 1'b1;
        op_o.kind     = bbc_pkg::KindSquare;
      end
      default: begin
        op_o.is_open  = 1'b0;
        op_o.is_close = 1'b0;
      end
    endcase
  end

  assign op_valid_o = ch_valid_i;
  assign ch_ready_o = op_ready_i;

endmodule

// File: hdl/bbc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_queue: short operation queue
// Decouple the classifier from the stack engine so each side stalls alone.
// ----------------------------------------------------------------------------
module bbc_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_valid_i,
  output logic         wr_ready_o,
  input  bbc_pkg::op_t wr_op_i,
  output logic         rd_valid_o,
  input  logic         rd_ready_i,
  output bbc_pkg::op_t rd_op_o
);

  localparam int PtrW = (bbc_pkg::QueueDepth > 1) ? $clog2(bbc_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(bbc_pkg::QueueDepth + 1);

  bbc_pkg::op_t    slot_q [bbc_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign wr_ready_o = (count_q != CntW'(bbc_pkg::QueueDepth));
  assign rd_valid_o = (count_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_op_o    = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(bbc_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(bbc_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= wr_op_i;
    end
  end

endmodule

// File: hdl/bbc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_back: stack engine and result register
// Apply one op per cycle to the bracket stack unless a result waits; register the result.
// ----------------------------------------------------------------------------
module bbc_back #(
  parameter int STACK_DEPTH = bbc_pkg::StackDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [7:0]   stack_limit_i,
  input  logic         op_valid_i,
  output logic         op_ready_o,
  input  bbc_pkg::op_t op_i,
  output logic         res_valid_o,
  input  logic         res_ready_i,
  output logic         res_verdict_ready_o,
  output logic         res_expression_valid_o,
  output logic         res_error_seen_o,
  output logic [7:0]   res_depth_now_o
);

  localparam int CntW = $clog2(STACK_DEPTH + 1);
  localparam int IdxW = $clog2(STACK_DEPTH);
  localparam int CmpW = (CntW > 8) ? CntW : 8;

  // Top two entries live in registers; the RAM read runs one entry ahead.
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                err_q, err_d;
  bbc_pkg::kind_e      top_q, top_d;
  bbc_pkg::kind_e      sec_q, sec_d;
  logic [1:0]          ram_rdata;
  logic [IdxW-1:0]     ram_raddr;
  logic                take, push, pop, err_new;
  logic [CntW-1:0]     cnt_new;
  logic [CmpW-1:0]     cnt_ext;
  logic                can_push;

  logic                out_valid_q;
  logic                out_verdict_q, out_ok_q, out_err_q;
  logic [7:0]          out_depth_q;

  assign take       = op_valid_i && (!out_valid_q || res_ready_i);
  assign op_ready_o = !out_valid_q || res_ready_i;

  assign cnt_ext  = CmpW'(cnt_q);
  assign can_push = (cnt_ext < CmpW'(stack_limit_i)) && (cnt_ext < CmpW'(STACK_DEPTH));

  always_comb begin
    push    = 1'b0;
    pop     = 1'b0;
    err_new = err_q;
    if (take && !err_q) begin
      if (op_i.is_open) begin
        push = can_push;
      end else if (op_i.is_close) begin
        if ((cnt_q == '0) || (top_q != op_i.kind)) begin
          err_new = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end
    end
  end

  always_comb begin
    cnt_new = cnt_q;
    if (push) begin
      cnt_new = cnt_q + 1'b1;
    end else if (pop) begin
      cnt_new = cnt_q - 1'b1;
    end
    cnt_d = cnt_new;
    err_d = err_new;
    if (take && op_i.last) begin
      cnt_d = '0;
      err_d = 1'b0;
    end
  end

  always_comb begin
    top_d = top_q;
    sec_d = sec_q;
    if (push) begin
      top_d = op_i.kind;
      sec_d = top_q;
    end else if (pop) begin
      top_d = sec_q;
      sec_d = bbc_pkg::kind_e'(ram_rdata);
    end
  end

  // Fetch the entry below the second one for the next cycle's count.
  assign ram_raddr = IdxW'(cnt_d - CntW'(3));

  bbc_ram #(
    .Width (2),
    .Depth (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (cnt_q[IdxW-1:0]),
    .wdata_i (op_i.kind),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      err_q <= err_d;
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    sec_q <= sec_d;
    if (take) begin
      out_verdict_q <= op_i.last;
      out_ok_q      <= op_i.last && !err_new && (cnt_new == '0);
      out_err_q     <= err_new;
      out_depth_q   <= 8'(cnt_new);
    end
  end

  assign res_valid_o            = out_valid_q;
  assign res_verdict_ready_o    = out_verdict_q;
  assign res_expression_valid_o = out_ok_q;
  assign res_error_seen_o       = out_err_q;
  assign res_depth_now_o        = out_depth_q;

endmodule

// File: hdl/bracket_balance_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_balance_checker: streaming bracket balance checker
// Checks that (), {} and [] nest and match in a character stream.
// ----------------------------------------------------------------------------
// Usage:
//   Send one character per item on s_axis (tdata = character, tlast marks the
//   final character of an expression). Every item yields one result item on
//   m_axis: tlast is set on the verdict item, tdata carries the verdict, the
//   sticky error flag and the depth after that character.
//   Path: an accepted item is written into the queue, then the stack engine
//   takes it and its result is presented from the result register.
//   Throughput: one item per cycle while m_axis tready stays high; the
//   stack top sits in a register and the stack RAM read is prefetched one
//   entry ahead, so back-to-back pushes and pops need no wait.
//   Write the stack limit through cfg_wr_en_i / cfg_wr_data_i while idle.
//   Reset: stack empty, error clear, limit 100. The stack RAM needs no
//   clearing pass; an entry is only read after it was pushed.
//   Stall: if the receiver holds tready low, the result register holds and
//   a two-entry queue keeps accepting input until it fills, then s_axis
//   tready drops.
// ----------------------------------------------------------------------------
module bracket_balance_checker #(
  parameter int STACK_DEPTH = bbc_pkg::StackDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: stack limit
  input  logic        cfg_wr_en_i,
  input  logic [7:0]  cfg_wr_data_i,
  // input characters
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tlast,   // last
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] expression_valid, [1] error_seen,
                                      // [9:2] depth_now, [15:10] zero
  output logic        m_axis_tlast    // verdict_ready
);

  logic [7:0]   stack_limit_q;
  logic         fr_valid, fr_ready;
  bbc_pkg::op_t fr_op;
  logic         bk_valid, bk_ready;
  bbc_pkg::op_t bk_op;
  logic         res_ok, res_err;
  logic [7:0]   res_depth;

  // Hold the stack limit; the user only changes it between expressions (not enforced).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_limit_q <= bbc_pkg::LimitReset;
    end else if (cfg_wr_en_i) begin
      stack_limit_q <= cfg_wr_data_i;
    end
  end

  // Classify each character into an open, close or ignore operation.
  bbc_front u_front (
    .ch_valid_i (s_axis_tvalid),
    .ch_i       (s_axis_tdata),
    .last_i     (s_axis_tlast),
    .ch_ready_o (s_axis_tready),
    .op_valid_o (fr_valid),
    .op_o       (fr_op),
    .op_ready_i (fr_ready)
  );

  // Buffer classified operations between front and back.
  bbc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_op_i    (fr_op),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_op_o    (bk_op)
  );

  // Apply operations to the stack and register one result per item.
  bbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .stack_limit_i          (stack_limit_q),
    .op_valid_i             (bk_valid),
    .op_ready_o             (bk_ready),
    .op_i                   (bk_op),
    .res_valid_o            (m_axis_tvalid),
    .res_ready_i            (m_axis_tready),
    .res_verdict_ready_o    (m_axis_tlast),
    .res_expression_valid_o (res_ok),
    .res_error_seen_o       (res_err),
    .res_depth_now_o        (res_depth)
  );

  assign m_axis_tdata = {6'b0, res_depth, res_err, res_ok};

  // A passing verdict only comes on the final item, error-free and empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |->
      (m_axis_tlast && !m_axis_tdata[1] && (m_axis_tdata[9:2] == 8'd0)))
    else $error("verdict set without a clean, empty final item");

  // A clean, empty final item always passes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast && !m_axis_tdata[1] &&
     (m_axis_tdata[9:2] == 8'd0)) |-> m_axis_tdata[0])
    else $error("clean, empty expression not reported as valid");

endmodule

// File: sim/bracket_balance_checker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_balance_checker_tb: self-checking bench for the bracket checker
// Streams expressions through s_axis under random idling and backpressure,
// predicts every result item from a behavioral copy of the bracket stack,
// and compares each m_axis result field by field. Walks the stack limit
// through zero, one, small values, the stack depth and values beyond it.
// ----------------------------------------------------------------------------
module bracket_balance_checker_tb;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 80;   // length of a long receiver stall
  localparam int IdlePct    = 21;   // chance of an idle cycle on either side

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic       verdict_ready;
    logic       expression_valid;
    logic       error_seen;
    logic [7:0] depth_now;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_wr_en_i = 1'b0;
  logic [7:0]  cfg_wr_data_i = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;    // [7:0] ch
  logic        s_axis_tlast = 1'b0;    // last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [0] expression_valid, [1] error_seen,
                                       // [9:2] depth_now, [15:10] zero
  logic        m_axis_tlast;           // verdict_ready

  bracket_balance_checker u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock: 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bracket stack model: kinds held, depth, sticky error and the stack limit
  // --------------------------------------------------------------------------
  bbc_pkg::kind_e open_kinds [bbc_pkg::StackDepth];
  int             open_count = 0;
  bit             nest_error = 1'b0;
  logic [7:0]     model_limit = bbc_pkg::LimitReset;

  char_item_t chars_to_send [$];   // items waiting for the driver
  verdict_t   results_due [$];     // predicted results, oldest first
  int         items_queued = 0;
  int         mismatches = 0;
  int         cycle_count = 0;
  bit         calm = 1'b0;         // suppress random idling on both sides
  int         holds_asked = 0;     // long receiver stalls requested
  int         holds_done = 0;
  int         stall_left = 0;
  bit         in_accepted = 1'b0;  // s_axis handshake at the last rising edge

  // Advance the model by one character and return the result it yields.
  function automatic verdict_t balance_step(logic [7:0] ch, logic last);
    verdict_t       res;
    bbc_pkg::kind_e k;
    bit             opens;
    bit             closes;
    int             eff_limit;
    opens  = 1'b0;
    closes = 1'b0;
    k      = bbc_pkg::KindRound;
    case (ch)
      bbc_pkg::ChOpenRound:   begin opens  = 1'b1; k = bbc_pkg::KindRound;  end
      bbc_pkg::ChOpenCurly:   begin opens  = 1'b1; k = bbc_pkg::KindCurly;  end
      bbc_pkg::ChOpenSquare:  begin opens  = 1'b1; k = bbc_pkg::KindSquare; end
      bbc_pkg::ChCloseRound:  begin closes = 1'b1; k = bbc_pkg::KindRound;  end
      bbc_pkg::ChCloseCurly:  begin closes = 1'b1; k = bbc_pkg::KindCurly;  end
      bbc_pkg::ChCloseSquare: begin closes = 1'b1; k = bbc_pkg::KindSquare; end
      default: ;
    endcase
    // Cap the limit at the physical stack depth.
    eff_limit = (int'(model_limit) > bbc_pkg::StackDepth) ? bbc_pkg::StackDepth :
                int'(model_limit);
    // Once the error is set, hold everything until the last item.
    if (!nest_error) begin
      if (opens) begin
        // Drop the push silently when the stack is at its limit.
        if (open_count < eff_limit) begin
          open_kinds[open_count] = k;
          open_count++;
        end
      end else if (closes) begin
        if (open_count == 0 || open_kinds[open_count - 1] != k) begin
          nest_error = 1'b1;
        end else begin
          open_count--;
        end
      end
    end
    res.verdict_ready    = last;
    res.expression_valid = last && !nest_error && (open_count == 0);
    res.error_seen       = nest_error;
    res.depth_now        = open_count[7:0];
    // Clear for the next expression after the verdict is given.
    if (last) begin
      open_count = 0;
      nest_error = 1'b0;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers: build expressions into the send queue
  // --------------------------------------------------------------------------
  function automatic logic [7:0] open_char(bbc_pkg::kind_e k);
    case (k)
      bbc_pkg::KindCurly:  return bbc_pkg::ChOpenCurly;
      bbc_pkg::KindSquare: return bbc_pkg::ChOpenSquare;
      default:             return bbc_pkg::ChOpenRound;
    endcase
  endfunction

  function automatic logic [7:0] close_char(bbc_pkg::kind_e k);
    case (k)
      bbc_pkg::KindCurly:  return bbc_pkg::ChCloseCurly;
      bbc_pkg::KindSquare: return bbc_pkg::ChCloseSquare;
      default:             return bbc_pkg::ChCloseRound;
    endcase
  endfunction

  // Pick any byte that is not a bracket.
  function automatic logic [7:0] filler_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c inside {bbc_pkg::ChOpenRound, bbc_pkg::ChOpenCurly,
                         bbc_pkg::ChOpenSquare, bbc_pkg::ChCloseRound,
                         bbc_pkg::ChCloseCurly, bbc_pkg::ChCloseSquare});
    return c;
  endfunction

  task automatic push_char(logic [7:0] ch, logic last);
    chars_to_send.push_back('{ch: ch, last: last});
    items_queued++;
  endtask

  // Append a balanced nest with random filler, ending in filler or a stray close.
  task automatic add_balanced(int max_depth, int len);
    bbc_pkg::kind_e opened [$];
    bbc_pkg::kind_e k;
    int             r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40 && opened.size() < max_depth) begin
        k = bbc_pkg::kind_e'($urandom_range(0, 2));
        opened.push_back(k);
        push_char(open_char(k), 1'b0);
      end else if (r < 75 && opened.size() > 0) begin
        push_char(close_char(opened.pop_back()), 1'b0);
      end else begin
        push_char(filler_char(), 1'b0);
      end
    end
    while (opened.size() > 0) push_char(close_char(opened.pop_back()), 1'b0);
    push_char(($urandom_range(0, 1) != 0) ? filler_char() : bbc_pkg::ChCloseRound, 1'b1);
    // The trailing close always lands on an empty stack, since every open
    // was closed before it, which is just another case worth covering.
  endtask

  // Append a well-formed expression, then corrupt one character of it.
  task automatic add_broken();
    int first;
    int idx;
    first = chars_to_send.size();
    add_balanced($urandom_range(1, 6), $urandom_range(2, 16));
    idx = $urandom_range(first, chars_to_send.size() - 1);
    chars_to_send[idx].ch = ($urandom_range(0, 1) != 0) ?
                            close_char(bbc_pkg::kind_e'($urandom_range(0, 2))) :
                            open_char(bbc_pkg::kind_e'($urandom_range(0, 2)));
  endtask

  // Append random bytes ending in a last item.
  task automatic add_noise();
    int n;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) push_char(8'($urandom_range(0, 255)), i == n - 1);
  endtask

  // Append one deep nest that runs into the stack limit.
  task automatic add_deep(int n);
    bbc_pkg::kind_e opened [$];
    bbc_pkg::kind_e k;
    for (int i = 0; i < n; i++) begin
      k = bbc_pkg::kind_e'($urandom_range(0, 2));
      opened.push_back(k);
      push_char(open_char(k), 1'b0);
    end
    push_char(filler_char(), 1'b0);
    while (opened.size() > 1) push_char(close_char(opened.pop_back()), 1'b0);
    push_char(close_char(opened.pop_back()), 1'b1);
  endtask

  // Wait until nothing is queued, offered or outstanding.
  task automatic wait_idle();
    while (chars_to_send.size() != 0 || s_axis_tvalid || results_due.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_limit(logic [7:0] value);
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    model_limit    = value;
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b0;
  endtask

  // One random phase: set the limit, then queue a mix of expressions.
  task automatic run_phase(logic [7:0] lim, int budget, bit deep, bit squeeze);
    int start;
    int r;
    wait_idle();
    write_limit(lim);
    start = items_queued;
    if (squeeze) holds_asked++;
    if (deep) add_deep(130);
    while (items_queued - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        // Mostly shallow nests; now and then a depth bound up to 140, within 20 characters.
        add_balanced(($urandom_range(0, 9) == 0) ? $urandom_range(1, 140) :
                     $urandom_range(1, 6), $urandom_range(0, 20));
      end else if (r < 85) begin
        add_broken();
      end else begin
        add_noise();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer the next item at the falling edge once the last one is taken
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_chars
    char_item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_accepted) begin
      if (chars_to_send.size() > 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
        nxt = chars_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.ch;
        s_axis_tlast  <= nxt.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random backpressure, plus long stalls on request.
  always @(negedge clk_i) begin : drive_ready
    if (holds_asked != holds_done) begin
      stall_left = HoldCycles;
      holds_done++;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each accepted input, check each accepted result
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    verdict_t want;
    if (!rst_ni) begin
      in_accepted <= 1'b0;
    end else begin
      in_accepted <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready)
        results_due.push_back(balance_step(s_axis_tdata, s_axis_tlast));
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing expected", m_axis_tdata, 0);
        end else begin
          want = results_due.pop_front();
          if (m_axis_tlast !== want.verdict_ready)
            report_mismatch("verdict_ready", m_axis_tlast, want.verdict_ready);
          if (m_axis_tdata[0] !== want.expression_valid)
            report_mismatch("expression_valid", m_axis_tdata[0], want.expression_valid);
          if (m_axis_tdata[1] !== want.error_seen)
            report_mismatch("error_seen", m_axis_tdata[1], want.error_seen);
          if (m_axis_tdata[9:2] !== want.depth_now)
            report_mismatch("depth_now", m_axis_tdata[9:2], want.depth_now);
          if (m_axis_tdata[15:10] !== 6'd0)
            report_mismatch("tdata padding", m_axis_tdata[15:10], 0);
        end
      end
    end
  end

  // Watchdog: end the run if it stalls.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("bracket_balance_checker test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed cases, then random phases over the limit range
  // --------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed cases at the reset limit.
    push_char(bbc_pkg::ChOpenRound, 1'b0);                               // ()
    push_char(bbc_pkg::ChCloseRound, 1'b1);
    push_char(bbc_pkg::ChOpenCurly, 1'b0);                               // {[]}
    push_char(bbc_pkg::ChOpenSquare, 1'b0);
    push_char(bbc_pkg::ChCloseSquare, 1'b0);
    push_char(bbc_pkg::ChCloseCurly, 1'b1);
    push_char(bbc_pkg::ChOpenSquare, 1'b0);                              // wrong kind
    push_char(bbc_pkg::ChCloseRound, 1'b1);
    push_char(bbc_pkg::ChCloseCurly, 1'b1);                              // close on empty
    push_char(bbc_pkg::ChOpenRound, 1'b0);                               // error, then
    push_char(bbc_pkg::ChCloseSquare, 1'b0);                             // ignored chars
    push_char(bbc_pkg::ChOpenCurly, 1'b0);
    push_char(bbc_pkg::ChCloseRound, 1'b1);
    push_char(8'h00, 1'b1);                                              // lowest byte
    push_char(8'hFF, 1'b1);                                              // highest byte
    push_char(bbc_pkg::ChOpenSquare, 1'b1);                              // open at the end
    push_char(8'h55, 1'b0);
    push_char(8'hAA, 1'b1);

    // Lower the limit below the depth held mid-expression: held entries
    // stay, pushes drop until the depth falls below the new limit.
    for (int i = 0; i < 4; i++) push_char(bbc_pkg::ChOpenRound, 1'b0);
    wait_idle();
    write_limit(8'd2);
    push_char(bbc_pkg::ChOpenRound, 1'b0);
    for (int i = 0; i < 3; i++) push_char(bbc_pkg::ChCloseRound, 1'b0);
    push_char(bbc_pkg::ChCloseRound, 1'b1);

    // Random phases: limit of zero, one, small, full depth, beyond the depth.
    run_phase(8'd0,   250, 1'b0, 1'b0);
    run_phase(8'd1,   280, 1'b0, 1'b1);   // long receiver stall at the start
    calm = 1'b1;
    run_phase(8'd2,   280, 1'b0, 1'b0);   // no idling on either side
    wait_idle();
    calm = 1'b0;
    run_phase(8'd128, 250, 1'b1, 1'b0);
    run_phase(8'd255, 250, 1'b1, 1'b1);
    run_phase(8'($urandom_range(3, 127)), 280, 1'b0, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 280, 1'b0, 1'b0);

    // Drain and let the pipeline settle before the verdict.
    wait_idle();
    repeat (5) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("bracket_balance_checker test passed");
    end else begin
      $display("bracket_balance_checker test failed");
    end
    $finish;
  end

endmodule
